// ===== hdl/vector2d_alu_assert.svh =====
// Assertion shorthands for the vector ALU, clocked on clock, off during reset.
`ifndef VECTOR2D_ALU_ASSERT_SVH
`define VECTOR2D_ALU_ASSERT_SVH

// Same-cycle implication.
`define V2A_HOLDS(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("vector2d_alu check failed");

// Next-cycle implication.
`define V2A_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("vector2d_alu check failed");

`endif

// ===== hdl/v2alu_pkg.sv =====
package v2alu_pkg;

   localparam int WORD_BITS   = 32;
   localparam int FRAC_BITS   = 16;
   localparam int FIELD_BITS  = 32;
   localparam int FUNC_BITS   = 3;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [FUNC_BITS-1:0] {
      OP_ADD    = 3'd0,
      OP_SUB    = 3'd1,
      OP_SCALE  = 3'd2,
      OP_LENGTH = 3'd3,
      OP_NORM   = 3'd4,
      OP_NONE   = 3'd7
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [WORD_BITS-1:0]  ax;
      logic [WORD_BITS-1:0]  ay;
      logic [WORD_BITS-1:0]  bx;
      logic [WORD_BITS-1:0]  by;
      logic [WORD_BITS-1:0]  k;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

// ===== hdl/v2alu_front.sv =====
module v2alu_front import v2alu_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [5*FIELD_BITS-1:0]   req_tdata,
   input  logic [FUNC_BITS-1:0]      req_tuser,
   input  logic                      q_full,
   output logic                      push,
   output item_type                  item
);

   logic     vld_ff, vld_in;
   item_type item_ff, item_in;
   op_type   dec_op;
   logic     accept;

   always_comb begin
      unique case (req_tuser)
         OP_ADD:    dec_op = OP_ADD;
         OP_SUB:    dec_op = OP_SUB;
         OP_SCALE:  dec_op = OP_SCALE;
         OP_LENGTH: dec_op = OP_LENGTH;
         OP_NORM:   dec_op = OP_NORM;
         default:   dec_op = OP_NONE;
      endcase
   end

   // keep the low word bits of each field
   always_comb begin
      item_in.op = dec_op;
      item_in.ax = WORD_BITS'(req_tdata[0*FIELD_BITS +: FIELD_BITS]);
      item_in.ay = WORD_BITS'(req_tdata[1*FIELD_BITS +: FIELD_BITS]);
      item_in.bx = WORD_BITS'(req_tdata[2*FIELD_BITS +: FIELD_BITS]);
      item_in.by = WORD_BITS'(req_tdata[3*FIELD_BITS +: FIELD_BITS]);
      item_in.k  = WORD_BITS'(req_tdata[4*FIELD_BITS +: FIELD_BITS]);
   end

   assign req_tready = !vld_ff || !q_full;
   assign accept     = req_tvalid && req_tready;
   assign push       = vld_ff && !q_full;
   assign item       = item_ff;

   always_comb begin
      vld_in = vld_ff;
      if (accept) begin
         vld_in = 1'b1;
      end else if (push) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

// ===== hdl/v2alu_queue.sv =====
module v2alu_queue import v2alu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  item_type   din,
   input  logic       pop,
   output item_type   dout,
   output q_stat_type q_stat
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   item_type            mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   assign dout         = mem_ff[rd_ptr_ff];
   assign q_stat.full  = (cnt_ff == CNT_BITS'(QUEUE_DEPTH));
   assign q_stat.empty = (cnt_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// ===== hdl/v2alu_back.sv =====
module v2alu_back import v2alu_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  q_stat_type                q_stat,
   input  item_type                  q_item,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [3*FIELD_BITS-1:0]   rsp_tdata,
   output logic [1:0]                rsp_tuser
);

   localparam int WB   = WORD_BITS;
   localparam int DW   = WORD_BITS + FRAC_BITS;
   localparam int SW   = 2 * WORD_BITS;
   localparam int RW   = WORD_BITS + 2;
   localparam int NSTG = 3 + WB + DW;
   localparam logic [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);
   localparam logic [WB-1:0] WORD_HI = {1'b0, {(WB-1){1'b1}}};
   localparam logic [WB-1:0] WORD_LO = {1'b1, {(WB-1){1'b0}}};

   typedef struct packed {
      op_type          op;
      logic [SW-1:0]   px;
      logic [SW-1:0]   py;
      logic [SW-1:0]   sx;
      logic [SW-1:0]   sy;
      logic [WB:0]     sum_x;
      logic [WB:0]     sum_y;
      logic [WB-1:0]   ax;
      logic [WB-1:0]   ay;
   } s0_type;

   typedef struct packed {
      logic [WB-1:0] x;
      logic [WB-1:0] y;
      logic          sat;
   } pre_type;

   typedef struct packed {
      op_type          op;
      pre_type         pre;
      logic            nx;
      logic            ny;
      logic [WB-1:0]   ux;
      logic [WB-1:0]   uy;
      logic [SW-1:0]   n;
      logic [RW-1:0]   r;
      logic [WB-1:0]   q;
   } sq_type;

   typedef struct packed {
      logic [WB:0]     r;
      logic [DW-1:0]   dq;
   } lane_type;

   typedef struct packed {
      op_type          op;
      pre_type         pre;
      logic            nx;
      logic            ny;
      logic [WB-1:0]   mag;
      lane_type        lx;
      lane_type        ly;
   } dv_type;

   typedef struct packed {
      logic          sat;
      logic [WB-1:0] val;
   } clamp_type;

   typedef struct packed {
      logic [WB-1:0] x;
      logic [WB-1:0] y;
      logic [WB-1:0] mag;
      logic          zl;
      logic          sat;
   } out_type;

   function automatic clamp_type clamp_word(input logic [SW-1:0] v);
      clamp_type c;
      if (&v[SW-1:WB-1] || ~|v[SW-1:WB-1]) begin
         c.sat = 1'b0;
         c.val = v[WB-1:0];
      end else begin
         c.sat = 1'b1;
         c.val = v[SW-1] ? WORD_LO : WORD_HI;
      end
      return c;
   endfunction

   // one root bit per stage: bring down two radicand bits, try 4q+1
   function automatic sq_type sqrt_step(input sq_type s);
      sq_type         o;
      logic [RW+1:0]  rr;
      logic [RW+1:0]  t;
      o    = s;
      rr   = {s.r, s.n[SW-1 -: 2]};
      t    = {2'b00, s.q, 2'b01};
      o.n  = {s.n[SW-3:0], 2'b00};
      if (rr >= t) begin
         o.r = RW'(rr - t);
         o.q = {s.q[WB-2:0], 1'b1};
      end else begin
         o.r = RW'(rr);
         o.q = {s.q[WB-2:0], 1'b0};
      end
      return o;
   endfunction

   // one restoring division bit; quotient shifts in where the dividend leaves
   function automatic lane_type div_lane(input lane_type l, input logic [WB-1:0] d);
      lane_type    o;
      logic [WB:0] t;
      t    = {l.r[WB-1:0], l.dq[DW-1]};
      o.dq = {l.dq[DW-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
         o.r     = t - {1'b0, d};
         o.dq[0] = 1'b1;
      end else begin
         o.r = t;
      end
      return o;
   endfunction

   function automatic dv_type div_step(input dv_type s);
      dv_type o;
      o    = s;
      o.lx = div_lane(s.lx, s.mag);
      o.ly = div_lane(s.ly, s.mag);
      return o;
   endfunction

   function automatic clamp_type fix_quot(input logic neg, input logic [DW-1:0] q);
      clamp_type     c;
      logic [DW-1:0] lim;
      lim = neg ? {{(DW-WB){1'b0}}, 1'b1, {(WB-1){1'b0}}}
                : {{(DW-WB+1){1'b0}}, {(WB-1){1'b1}}};
      if (q > lim) begin
         c.sat = 1'b1;
         c.val = neg ? WORD_LO : WORD_HI;
      end else begin
         c.sat = 1'b0;
         c.val = neg ? (~q[WB-1:0]) + 1'b1 : q[WB-1:0];
      end
      return c;
   endfunction

   logic [NSTG-1:0] vld_ff, vld_in;
   logic            en;

   s0_type  s0_ff, s0_in;
   sq_type  s1_ff, s1_in;
   sq_type  sq_ff [WB];
   sq_type  sq_in [WB];
   dv_type  dv_init;
   dv_type  dv_ff [DW];
   dv_type  dv_in [DW];
   out_type out_ff, out_in;

   logic signed [SW-1:0] axe, aye, ke;
   logic signed [WB:0]   a1x, a1y, b1x, b1y;
   logic signed [SW-1:0] scx, scy;
   clamp_type            cx, cy, qx, qy;
   dv_type               dl;

   // whole pipe advances unless the finished item is held at the output
   assign en         = !vld_ff[NSTG-1] || rsp_tready;
   assign pop        = !q_stat.empty && en;
   assign vld_in     = {vld_ff[NSTG-2:0], pop};
   assign rsp_tvalid = vld_ff[NSTG-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // products and sums
   always_comb begin
      axe = SW'($signed(q_item.ax));
      aye = SW'($signed(q_item.ay));
      ke  = SW'($signed(q_item.k));
      a1x = (WB+1)'($signed(q_item.ax));
      a1y = (WB+1)'($signed(q_item.ay));
      b1x = (WB+1)'($signed(q_item.bx));
      b1y = (WB+1)'($signed(q_item.by));
      s0_in.op    = q_item.op;
      s0_in.px    = axe * ke;
      s0_in.py    = aye * ke;
      s0_in.sx    = axe * axe;
      s0_in.sy    = aye * aye;
      s0_in.sum_x = (q_item.op == OP_SUB) ? a1x - b1x : a1x + b1x;
      s0_in.sum_y = (q_item.op == OP_SUB) ? a1y - b1y : a1y + b1y;
      s0_in.ax    = q_item.ax;
      s0_in.ay    = q_item.ay;
   end

   // round, clamp, and set up the root
   always_comb begin
      scx = $signed(s0_ff.px + HALF) >>> FRAC_BITS;
      scy = $signed(s0_ff.py + HALF) >>> FRAC_BITS;
      cx  = '0;
      cy  = '0;
      unique case (s0_ff.op) inside
         OP_ADD, OP_SUB: begin
            cx = clamp_word(SW'($signed(s0_ff.sum_x)));
            cy = clamp_word(SW'($signed(s0_ff.sum_y)));
         end
         OP_SCALE: begin
            cx = clamp_word(scx);
            cy = clamp_word(scy);
         end
         default: begin
         end
      endcase
      s1_in.op      = s0_ff.op;
      s1_in.pre.x   = cx.val;
      s1_in.pre.y   = cy.val;
      s1_in.pre.sat = cx.sat || cy.sat;
      s1_in.nx      = s0_ff.ax[WB-1];
      s1_in.ny      = s0_ff.ay[WB-1];
      s1_in.ux      = s0_ff.ax[WB-1] ? -s0_ff.ax : s0_ff.ax;
      s1_in.uy      = s0_ff.ay[WB-1] ? -s0_ff.ay : s0_ff.ay;
      s1_in.n       = s0_ff.sx + s0_ff.sy;
      s1_in.r       = '0;
      s1_in.q       = '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_ff <= s0_in;
         s1_ff <= s1_in;
      end
   end

   for (genvar j = 0; j < WB; j++) begin : g_sqrt
      if (j == 0) begin : g_first
         assign sq_in[j] = sqrt_step(s1_ff);
      end else begin : g_next
         assign sq_in[j] = sqrt_step(sq_ff[j-1]);
      end
      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[j] <= sq_in[j];
         end
      end
   end

   always_comb begin
      dv_init.op    = sq_ff[WB-1].op;
      dv_init.pre   = sq_ff[WB-1].pre;
      dv_init.nx    = sq_ff[WB-1].nx;
      dv_init.ny    = sq_ff[WB-1].ny;
      dv_init.mag   = sq_ff[WB-1].q;
      dv_init.lx.r  = '0;
      dv_init.lx.dq = {sq_ff[WB-1].ux, {FRAC_BITS{1'b0}}};
      dv_init.ly.r  = '0;
      dv_init.ly.dq = {sq_ff[WB-1].uy, {FRAC_BITS{1'b0}}};
   end

   for (genvar j = 0; j < DW; j++) begin : g_div
      if (j == 0) begin : g_first
         assign dv_in[j] = div_step(dv_init);
      end else begin : g_next
         assign dv_in[j] = div_step(dv_ff[j-1]);
      end
      always_ff @(posedge clock) begin
         if (en) begin
            dv_ff[j] <= dv_in[j];
         end
      end
   end

   // apply signs, clamp quotients, pick fields per operation
   always_comb begin
      dl         = dv_ff[DW-1];
      qx         = fix_quot(dl.nx, dl.lx.dq);
      qy         = fix_quot(dl.ny, dl.ly.dq);
      out_in.x   = dl.pre.x;
      out_in.y   = dl.pre.y;
      out_in.sat = dl.pre.sat;
      out_in.mag = '0;
      out_in.zl  = 1'b0;
      unique case (dl.op) inside
         OP_LENGTH: begin
            out_in.mag = dl.mag;
         end
         OP_NORM: begin
            out_in.mag = dl.mag;
            if (dl.mag == '0) begin
               out_in.zl  = 1'b1;
               out_in.x   = '0;
               out_in.y   = '0;
               out_in.sat = 1'b0;
            end else begin
               out_in.x   = qx.val;
               out_in.y   = qy.val;
               out_in.sat = qx.sat || qy.sat;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tdata = {FIELD_BITS'(out_ff.mag),
                       FIELD_BITS'($signed(out_ff.y)),
                       FIELD_BITS'($signed(out_ff.x))};
   assign rsp_tuser = {out_ff.sat, out_ff.zl};

endmodule

// ===== hdl/vector2d_alu.sv =====
// 2D vector ALU on signed Q16.16: add, subtract, scale, length and normalize.
// One item in, one item out, in order. A new item is taken every cycle while
// the output side keeps up; every operation runs through the same pipeline,
// in which the Q16.16 operands pass the one-bit-per-stage square root
// (WORD_BITS stages) and then the one-bit-per-stage divider (WORD_BITS +
// FRAC_BITS stages). A four-item queue sits between the input register and
// that pipeline. Function codes 5 to 7 give an all-zero result.
`include "vector2d_alu_assert.svh"

module vector2d_alu import v2alu_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // a_x, a_y, b_x, b_y, scale_factor
   input  logic [5*FIELD_BITS-1:0]   req_tdata,
   // func
   input  logic [FUNC_BITS-1:0]      req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // result_x, result_y, magnitude
   output logic [3*FIELD_BITS-1:0]   rsp_tdata,
   // zero_length, saturated
   output logic [1:0]                rsp_tuser
);

   logic       push;
   logic       pop;
   item_type   f_item;
   item_type   q_item;
   q_stat_type q_stat;

   v2alu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_stat.full),
      .push       (push),
      .item       (f_item)
   );

   v2alu_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .din    (f_item),
      .pop    (pop),
      .dout   (q_item),
      .q_stat (q_stat)
   );

   v2alu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .q_item     (q_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   `V2A_HOLDS(a_no_push_when_full, q_stat.full, !push)
   `V2A_HOLDS(a_no_pop_when_empty, q_stat.empty, !pop)
   `V2A_NEXT(a_push_fills_queue, push, !q_stat.empty)
   `V2A_HOLDS(a_zero_len_clean, rsp_tvalid && rsp_tuser[0], rsp_tdata == '0 && !rsp_tuser[1])

endmodule
